>>> rtl/kwl_pkg.sv
// ----------------------------------------------------------------------------
// kwl_pkg
// Types, token codes and keyword tables shared by the keyword lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package kwl_pkg;

    localparam int NKEYS   = 9;
    localparam int NSINGLE = 7;

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_IDENT  = 2'd1,
        MODE_NUMBER = 2'd2
    } scan_mode_t;

    // Token kinds. Kinds 0 to 6 are the one-character tokens in table order.
    localparam logic [4:0] KIND_INCLUDE = 5'd7;
    localparam logic [4:0] KIND_RETURN  = 5'd8;
    localparam logic [4:0] KIND_TYPE    = 5'd9;
    localparam logic [4:0] KIND_IF      = 5'd10;
    localparam logic [4:0] KIND_ELSE    = 5'd11;
    localparam logic [4:0] KIND_FOR     = 5'd12;
    localparam logic [4:0] KIND_EXIT    = 5'd13;
    localparam logic [4:0] KIND_IDENT   = 5'd14;
    localparam logic [4:0] KIND_INT     = 5'd15;
    localparam logic [4:0] KIND_FLOAT   = 5'd16;
    localparam logic [4:0] KIND_OTHER   = 5'd17;
    localparam logic [4:0] KIND_END     = 5'd18;

    localparam logic [1:0] TYPE_NONE   = 2'd0;
    localparam logic [1:0] TYPE_FLOAT  = 2'd1;
    localparam logic [1:0] TYPE_DOUBLE = 2'd2;
    localparam logic [1:0] TYPE_INT    = 2'd3;

    localparam logic [7:0] CHAR_DOT = 8'h2E;

    localparam logic [7:0] SINGLE_CHAR [NSINGLE] = '{
        8'h3B, 8'h3D, 8'h28, 8'h29, 8'h7B, 8'h7D, 8'h2C
    };

    // Keyword text, left aligned in a 7-character word.
    localparam logic [55:0] KEY_TEXT [NKEYS] = '{
        "include",
        {"return", 8'h00},
        {"float", 16'h0000},
        {"double", 8'h00},
        {"int", 32'h0000_0000},
        {"if", 40'h00_0000_0000},
        {"else", 24'h00_0000},
        {"for", 32'h0000_0000},
        {"exit", 24'h00_0000}
    };

    localparam logic [2:0] KEY_LEN [NKEYS] = '{
        3'd7, 3'd6, 3'd5, 3'd6, 3'd3, 3'd2, 3'd4, 3'd3, 3'd4
    };

    localparam logic [4:0] KEY_KIND [NKEYS] = '{
        KIND_INCLUDE, KIND_RETURN, KIND_TYPE, KIND_TYPE, KIND_TYPE,
        KIND_IF, KIND_ELSE, KIND_FOR, KIND_EXIT
    };

    localparam logic [1:0] KEY_TYPE [NKEYS] = '{
        TYPE_NONE, TYPE_NONE, TYPE_FLOAT, TYPE_DOUBLE, TYPE_INT,
        TYPE_NONE, TYPE_NONE, TYPE_NONE, TYPE_NONE
    };

    typedef struct packed {
        scan_mode_t         mode;
        logic [NKEYS-1:0]   match;
        logic [7:0]         len;
        logic               dot;
        logic               ovf;
    } kwl_state_t;

    localparam kwl_state_t CLEAR_STATE = '{
        mode: MODE_IDLE, match: '0, len: 8'd0, dot: 1'b0, ovf: 1'b0
    };

    typedef struct packed {
        logic       is_token;
        logic [4:0] token_kind;
        logic [1:0] type_code;
        logic [7:0] char_value;
        logic [7:0] text_length;
        logic       text_overflow;
        logic       last;
    } kwl_result_t;

    // Character at a position of a left-aligned keyword word.
    function automatic logic [7:0] key_char(input logic [55:0] word, input logic [2:0] pos);
        logic [7:0] ch;
        unique case (pos)
            3'd0:    ch = word[55:48];
            3'd1:    ch = word[47:40];
            3'd2:    ch = word[39:32];
            3'd3:    ch = word[31:24];
            3'd4:    ch = word[23:16];
            3'd5:    ch = word[15:8];
            3'd6:    ch = word[7:0];
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

endpackage

`default_nettype wire

>>> rtl/kwl_step.sv
// ----------------------------------------------------------------------------
// kwl_step
// Lexer next-state logic for one character: up to two results per item.
// ----------------------------------------------------------------------------
`default_nettype none

module kwl_step #(
    parameter int MAX_TEXT_LENGTH = 255
) (
    input  wire kwl_pkg::kwl_state_t  state_cur,
    input  wire logic [7:0]           char_code,
    input  wire logic                 end_of_input,
    output kwl_pkg::kwl_state_t       state_nxt,
    output kwl_pkg::kwl_result_t      first_res,
    output kwl_pkg::kwl_result_t      second_res,
    output logic [1:0]                res_count
);

    localparam logic [7:0] LEN_CAP =
        (MAX_TEXT_LENGTH < 255) ? 8'(MAX_TEXT_LENGTH) : 8'd255;

    logic is_space, is_alpha, is_digit, is_dot;
    logic single_hit;
    logic [4:0] single_kind;
    logic cont;
    logic fin_valid;
    kwl_pkg::kwl_result_t fin_res;
    kwl_pkg::kwl_state_t add_in;
    kwl_pkg::kwl_state_t grown;
    logic do_add;
    logic plain_valid;
    kwl_pkg::kwl_result_t plain_res;
    logic [kwl_pkg::NKEYS-1:0] keep;
    logic sec_valid;
    kwl_pkg::kwl_result_t sec_res;

    assign is_space = (char_code == 8'd32) || (char_code >= 8'd9 && char_code <= 8'd13);
    assign is_alpha = (char_code >= 8'd65 && char_code <= 8'd90)
                   || (char_code >= 8'd97 && char_code <= 8'd122);
    assign is_digit = (char_code >= 8'd48) && (char_code <= 8'd57);
    assign is_dot   = (char_code == kwl_pkg::CHAR_DOT);

    always_comb
    begin
        single_hit  = 1'b0;
        single_kind = 5'd0;
        for (int k = 0; k < kwl_pkg::NSINGLE; k++)
        begin
            if (char_code == kwl_pkg::SINGLE_CHAR[k])
            begin
                single_hit  = 1'b1;
                single_kind = 5'(k);
            end
        end
    end

    // The character extends the pending identifier or number.
    assign cont = !end_of_input
               && (((state_cur.mode == kwl_pkg::MODE_IDENT) && (is_alpha || is_digit))
                || ((state_cur.mode == kwl_pkg::MODE_NUMBER)
                    && (is_digit || (is_dot && !state_cur.dot))));

    assign fin_valid = (state_cur.mode != kwl_pkg::MODE_IDLE) && (end_of_input || !cont);

    // Completed token for the pending text.
    always_comb
    begin
        fin_res               = '0;
        fin_res.is_token      = 1'b1;
        fin_res.text_length   = state_cur.len;
        fin_res.text_overflow = state_cur.ovf;
        if (state_cur.mode == kwl_pkg::MODE_IDENT)
        begin
            fin_res.token_kind = kwl_pkg::KIND_IDENT;
            if (!state_cur.ovf)
            begin
                for (int k = 0; k < kwl_pkg::NKEYS; k++)
                begin
                    if (state_cur.match[k] && (state_cur.len == {5'd0, kwl_pkg::KEY_LEN[k]}))
                    begin
                        fin_res.token_kind = kwl_pkg::KEY_KIND[k];
                        fin_res.type_code  = kwl_pkg::KEY_TYPE[k];
                    end
                end
            end
        end
        else
        begin
            fin_res.token_kind = state_cur.dot ? kwl_pkg::KIND_FLOAT : kwl_pkg::KIND_INT;
        end
    end

    // Decide what the character does once any pending token is closed.
    always_comb
    begin
        add_in      = kwl_pkg::CLEAR_STATE;
        do_add      = 1'b0;
        plain_valid = 1'b0;
        plain_res   = '0;
        if (end_of_input)
        begin
            plain_valid          = 1'b1;
            plain_res.is_token   = 1'b1;
            plain_res.token_kind = kwl_pkg::KIND_END;
        end
        else if (cont)
        begin
            add_in = state_cur;
            if (is_dot)
            begin
                add_in.dot = 1'b1;
            end
            do_add = 1'b1;
        end
        else
        begin
            priority if (is_space)
            begin
                plain_valid = 1'b0;
            end
            else if (single_hit)
            begin
                plain_valid          = 1'b1;
                plain_res.is_token   = 1'b1;
                plain_res.token_kind = single_kind;
                plain_res.char_value = char_code;
            end
            else if (is_alpha)
            begin
                add_in.mode  = kwl_pkg::MODE_IDENT;
                add_in.match = '1;
                do_add       = 1'b1;
            end
            else if (is_digit || is_dot)
            begin
                add_in.mode = kwl_pkg::MODE_NUMBER;
                add_in.dot  = is_dot;
                do_add      = 1'b1;
            end
            else
            begin
                plain_valid          = 1'b1;
                plain_res.is_token   = 1'b1;
                plain_res.token_kind = kwl_pkg::KIND_OTHER;
                plain_res.char_value = char_code;
            end
        end
    end

    // Append the character: narrow the keyword candidates and count length.
    always_comb
    begin
        for (int k = 0; k < kwl_pkg::NKEYS; k++)
        begin
            keep[k] = (add_in.len < {5'd0, kwl_pkg::KEY_LEN[k]})
                   && (kwl_pkg::key_char(kwl_pkg::KEY_TEXT[k], add_in.len[2:0]) == char_code);
        end
        grown       = add_in;
        grown.match = add_in.match & keep;
        if (add_in.len < LEN_CAP)
        begin
            grown.len = add_in.len + 8'd1;
        end
        else
        begin
            grown.ovf = 1'b1;
        end
    end

    always_comb
    begin
        state_nxt = kwl_pkg::CLEAR_STATE;
        sec_valid = plain_valid;
        sec_res   = plain_res;
        if (do_add)
        begin
            state_nxt             = grown;
            sec_valid             = 1'b1;
            sec_res               = '0;
            sec_res.char_value    = char_code;
            sec_res.text_length   = grown.len;
            sec_res.text_overflow = grown.ovf;
            if (grown.mode == kwl_pkg::MODE_IDENT)
            begin
                sec_res.token_kind = kwl_pkg::KIND_IDENT;
            end
            else
            begin
                sec_res.token_kind = grown.dot ? kwl_pkg::KIND_FLOAT : kwl_pkg::KIND_INT;
            end
        end
    end

    always_comb
    begin
        first_res       = fin_valid ? fin_res : sec_res;
        first_res.last  = !(fin_valid && sec_valid);
        second_res      = sec_res;
        second_res.last = 1'b1;
        res_count       = {1'b0, fin_valid} + {1'b0, sec_valid};
    end

endmodule

`default_nettype wire

>>> rtl/keyword_lexer_unit.sv
// ----------------------------------------------------------------------------
// keyword_lexer_unit
// Character-at-a-time tokenizer with parallel keyword matching.
// ----------------------------------------------------------------------------
//  Channel  Handshake               Payload
//  char     char_valid/char_ready   char_code, end_of_input
//  tok      tok_valid/tok_ready     is_token, token_kind, type_code,
//                                   char_value, text_length, text_overflow, last
//
// A request is taken in any cycle with char_ready high; its one or two
// results enter a two-entry result register at that edge and leave one per
// cycle while tok_ready is high, holding the output until both are taken.
// A new request is taken when the result register is empty or drains its
// last entry in that cycle. Reset returns the lexer to idle with no results.
// ----------------------------------------------------------------------------
`default_nettype none

module keyword_lexer_unit #(
    parameter int MAX_TEXT_LENGTH = 255
) (
    input  wire  logic       clk,
    input  wire  logic       rst_n,
    input  wire  logic       char_valid,
    output logic             char_ready,
    input  wire  logic [7:0] char_code,
    input  wire  logic       end_of_input,
    output logic             tok_valid,
    input  wire  logic       tok_ready,
    output logic             is_token,
    output logic [4:0]       token_kind,
    output logic [1:0]       type_code,
    output logic [7:0]       char_value,
    output logic [7:0]       text_length,
    output logic             text_overflow,
    output logic             last
);

    kwl_pkg::kwl_state_t  state_reg;
    kwl_pkg::kwl_state_t  state_next;
    kwl_pkg::kwl_result_t first_res, second_res;
    kwl_pkg::kwl_result_t slot0_reg, slot0_next;
    kwl_pkg::kwl_result_t slot1_reg, slot1_next;
    logic [1:0]           count_reg, count_next;
    logic [1:0]           res_count;
    logic                 accept;
    logic                 pop;

    kwl_step #(
        .MAX_TEXT_LENGTH (MAX_TEXT_LENGTH)
    ) u_step (
        .state_cur    (state_reg),
        .char_code    (char_code),
        .end_of_input (end_of_input),
        .state_nxt    (state_next),
        .first_res    (first_res),
        .second_res   (second_res),
        .res_count    (res_count)
    );

    assign tok_valid  = (count_reg != 2'd0);
    assign pop        = tok_valid && tok_ready;
    assign char_ready = (count_reg == 2'd0) || ((count_reg == 2'd1) && tok_ready);
    assign accept     = char_valid && char_ready;

    // Accepting only happens when the register is empty after this cycle.
    always_comb
    begin
        count_next = count_reg;
        slot0_next = slot0_reg;
        slot1_next = slot1_reg;
        if (accept)
        begin
            count_next = res_count;
            slot0_next = first_res;
            slot1_next = second_res;
        end
        else if (pop)
        begin
            count_next = count_reg - 2'd1;
            slot0_next = slot1_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= kwl_pkg::CLEAR_STATE;
            count_reg <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                state_reg <= state_next;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        slot0_reg <= slot0_next;
        slot1_reg <= slot1_next;
    end

    assign is_token      = slot0_reg.is_token;
    assign token_kind    = slot0_reg.token_kind;
    assign type_code     = slot0_reg.type_code;
    assign char_value    = slot0_reg.char_value;
    assign text_length   = slot0_reg.text_length;
    assign text_overflow = slot0_reg.text_overflow;
    assign last          = slot0_reg.last;

endmodule

`default_nettype wire
